### hw/rtl/vtm_pkg.sv
// Package for the virtual timer multiplexer.
// Holds sizes, opcodes, result kinds, the controller state type and the
// command and status structs. Depends on nothing.
`default_nettype none

package vtm_pkg;

  localparam int NUM_TIMERS = 8;
  localparam int SLOT_W     = $clog2(NUM_TIMERS);
  localparam int CNT_W      = $clog2(NUM_TIMERS + 1);
  localparam int TIME_W     = 32;
  localparam int PCNT_W     = 9;
  localparam int SHIFT_W    = 4;
  localparam int OP_W       = 2;
  localparam int KIND_W     = 3;
  localparam int ID_W       = 3;

  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd4;
  localparam logic [SHIFT_W-1:0] SHIFT_MAX   = 4'd9;

  localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
  localparam logic [OP_W-1:0] OP_ONCE   = 2'd1;
  localparam logic [OP_W-1:0] OP_REPEAT = 2'd2;
  localparam logic [OP_W-1:0] OP_CANCEL = 2'd3;

  localparam logic [KIND_W-1:0] KIND_FIRED     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_STARTED   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CANCELLED = 3'd2;
  localparam logic [KIND_W-1:0] KIND_NO_FREE   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NOT_FOUND = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_EMIT = 4'b0100,
    S_EXEC = 4'b1000
  } state_t;

  typedef struct packed {
    logic              accept;
    logic              tick;
    logic              scan;
    logic [SLOT_W-1:0] idx;
    logic              pop;
    logic              exec;
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_one;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

### hw/rtl/vtm_in_if.sv
// Input channel interface of the virtual timer multiplexer.
// Carries valid, ready and the request payload; depends on vtm_pkg.
`default_nettype none

interface vtm_in_if;
  logic                        valid;
  logic                        ready;
  logic [vtm_pkg::OP_W-1:0]    opcode;
  logic [vtm_pkg::TIME_W-1:0]  duration;
  logic [vtm_pkg::ID_W-1:0]    target_id;

  modport source (output valid, output opcode, output duration, output target_id,
                  input ready);
  modport sink (input valid, input opcode, input duration, input target_id,
                output ready);
endinterface

`default_nettype wire

### hw/rtl/vtm_out_if.sv
// Result channel interface of the virtual timer multiplexer.
// Carries valid, ready and the result payload; depends on vtm_pkg.
`default_nettype none

interface vtm_out_if;
  logic                       valid;
  logic                       ready;
  logic [vtm_pkg::KIND_W-1:0] result_kind;
  logic [vtm_pkg::ID_W-1:0]   slot_id;
  logic                       last;

  modport source (output valid, output result_kind, output slot_id, output last,
                  input ready);
  modport sink (input valid, input result_kind, input slot_id, input last,
                output ready);
endinterface

`default_nettype wire

### hw/rtl/vtm_ctrl.sv
// Controller state machine of the virtual timer multiplexer.
// Sequences accept, slot scan, fire emission and start or cancel; uses vtm_pkg.
`default_nettype none

module vtm_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  input  wire logic [vtm_pkg::OP_W-1:0] in_opcode,
  output logic                          in_ready,
  input  wire vtm_pkg::status_t         status,
  output vtm_pkg::cmd_t                 cmd
);

  vtm_pkg::state_t                   state_r, state_nxt;
  logic [vtm_pkg::SLOT_W-1:0]        idx_r, idx_nxt;
  logic                              accept;

  assign in_ready = (state_r == vtm_pkg::S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    cmd        = '0;
    cmd.idx    = idx_r;
    cmd.accept = accept;
    unique case (state_r)
      vtm_pkg::S_IDLE: begin
        if (accept) begin
          idx_nxt = '0;
          if (in_opcode == vtm_pkg::OP_TICK) begin
            cmd.tick  = 1'b1;
            state_nxt = vtm_pkg::S_SCAN;
          end else begin
            state_nxt = vtm_pkg::S_EXEC;
          end
        end
      end
      vtm_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
        idx_nxt  = idx_r + 1'b1;
        if (idx_r == vtm_pkg::SLOT_W'(vtm_pkg::NUM_TIMERS - 1)) begin
          state_nxt = vtm_pkg::S_EMIT;
        end
      end
      vtm_pkg::S_EMIT: begin
        if (status.cnt_zero) begin
          state_nxt = vtm_pkg::S_IDLE;
        end else if (status.out_free) begin
          cmd.pop = 1'b1;
          if (status.cnt_one) begin
            state_nxt = vtm_pkg::S_IDLE;
          end
        end
      end
      vtm_pkg::S_EXEC: begin
        if (status.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = vtm_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = vtm_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vtm_pkg::S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/vtm_datapath.sv
// Datapath of the virtual timer multiplexer: time base, slot registers,
// deadline-ordered fire list and the result register; uses vtm_pkg.
`default_nettype none

module vtm_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire vtm_pkg::cmd_t               cmd,
  output vtm_pkg::status_t                 status,
  input  wire logic                        cfg_we,
  input  wire logic [vtm_pkg::SHIFT_W-1:0] cfg_wdata,
  input  wire logic [vtm_pkg::OP_W-1:0]    in_opcode,
  input  wire logic [vtm_pkg::TIME_W-1:0]  in_duration,
  input  wire logic [vtm_pkg::ID_W-1:0]    in_target_id,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [vtm_pkg::KIND_W-1:0]       out_result_kind,
  output logic [vtm_pkg::ID_W-1:0]         out_slot_id,
  output logic                             out_last
);

  localparam int N  = vtm_pkg::NUM_TIMERS;
  localparam int TW = vtm_pkg::TIME_W;
  localparam int SW = vtm_pkg::SLOT_W;

  logic [vtm_pkg::SHIFT_W-1:0] shift_r, shift_nxt;
  logic [TW-1:0]               time_r, time_nxt;
  logic [vtm_pkg::PCNT_W-1:0]  pcnt_r, pcnt_nxt;
  logic [N-1:0]                active_r, active_nxt;
  logic [TW-1:0]               deadline_r [N];
  logic [TW-1:0]               deadline_nxt [N];
  logic [TW-1:0]               period_r [N];
  logic [TW-1:0]               period_nxt [N];

  logic [vtm_pkg::OP_W-1:0]    op_r, op_nxt;
  logic [TW-1:0]               dur_r, dur_nxt;
  logic [vtm_pkg::ID_W-1:0]    tid_r, tid_nxt;

  logic [SW-1:0]               ord_slot_r [N];
  logic [SW-1:0]               ord_slot_nxt [N];
  logic [TW-1:0]               ord_late_r [N];
  logic [TW-1:0]               ord_late_nxt [N];
  logic [vtm_pkg::CNT_W-1:0]   ord_cnt_r, ord_cnt_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [vtm_pkg::KIND_W-1:0]  kind_r, kind_nxt;
  logic [vtm_pkg::ID_W-1:0]    slot_r, slot_nxt;
  logic                        last_r, last_nxt;

  logic [vtm_pkg::SHIFT_W-1:0] sh_eff;
  logic [vtm_pkg::PCNT_W-1:0]  pcnt_top;
  logic [SW-1:0]               addr;
  logic [TW-1:0]               rd_deadline, rd_period;
  logic [TW-1:0]               diff, late;
  logic                        expired;
  logic [N-1:0]                ge;
  logic                        free_found;
  logic [SW-1:0]               free_idx;
  logic [SW-1:0]               tid_slot;
  logic                        out_free;

  assign sh_eff   = (shift_r > vtm_pkg::SHIFT_MAX) ? vtm_pkg::SHIFT_MAX : shift_r;
  assign pcnt_top = vtm_pkg::PCNT_W'(({1'b0, {vtm_pkg::PCNT_W{1'b0}}} + 1'b1) << sh_eff)
                    - 1'b1;

  assign addr        = cmd.scan ? cmd.idx : ord_slot_r[0];
  assign rd_deadline = deadline_r[addr];
  assign rd_period   = period_r[addr];
  assign diff        = rd_deadline - time_r;
  assign late        = time_r - rd_deadline;
  assign expired     = active_r[addr] && ((diff == '0) || diff[TW-1]);

  assign tid_slot = SW'(tid_r);
  assign out_free = !out_valid_r || out_ready;

  assign status.cnt_zero = (ord_cnt_r == '0);
  assign status.cnt_one  = (ord_cnt_r == vtm_pkg::CNT_W'(1));
  assign status.out_free = out_free;

  assign out_valid       = out_valid_r;
  assign out_result_kind = kind_r;
  assign out_slot_id     = slot_r;
  assign out_last        = last_r;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!active_r[i]) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      ge[i] = (vtm_pkg::CNT_W'(i) < ord_cnt_r) && (ord_late_r[i] >= late);
    end
  end

  always_comb begin
    shift_nxt     = cfg_we ? cfg_wdata : shift_r;
    time_nxt      = time_r;
    pcnt_nxt      = pcnt_r;
    active_nxt    = active_r;
    deadline_nxt  = deadline_r;
    period_nxt    = period_r;
    op_nxt        = op_r;
    dur_nxt       = dur_r;
    tid_nxt       = tid_r;
    ord_slot_nxt  = ord_slot_r;
    ord_late_nxt  = ord_late_r;
    ord_cnt_nxt   = ord_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    kind_nxt      = kind_r;
    slot_nxt      = slot_r;
    last_nxt      = last_r;

    if (cmd.accept) begin
      op_nxt  = in_opcode;
      dur_nxt = in_duration;
      tid_nxt = in_target_id;
    end

    if (cmd.tick) begin
      ord_cnt_nxt = '0;
      if (pcnt_r >= pcnt_top) begin
        pcnt_nxt = '0;
        time_nxt = time_r + 1'b1;
      end else begin
        pcnt_nxt = pcnt_r + 1'b1;
      end
    end

    // Insert the scanned slot so the list stays most overdue first; equal
    // lateness keeps the earlier, lower-indexed slot ahead.
    if (cmd.scan && expired) begin
      ord_cnt_nxt = ord_cnt_r + 1'b1;
      if (!ge[0]) begin
        ord_slot_nxt[0] = cmd.idx;
        ord_late_nxt[0] = late;
      end
      for (int i = 1; i < N; i++) begin
        if (!ge[i]) begin
          if (ge[i-1]) begin
            ord_slot_nxt[i] = cmd.idx;
            ord_late_nxt[i] = late;
          end else begin
            ord_slot_nxt[i] = ord_slot_r[i-1];
            ord_late_nxt[i] = ord_late_r[i-1];
          end
        end
      end
    end

    if (cmd.pop) begin
      ord_cnt_nxt = ord_cnt_r - 1'b1;
      for (int i = 0; i < N - 1; i++) begin
        ord_slot_nxt[i] = ord_slot_r[i+1];
        ord_late_nxt[i] = ord_late_r[i+1];
      end
      if (rd_period != '0) begin
        deadline_nxt[addr] = rd_deadline + rd_period;
      end else begin
        active_nxt[addr] = 1'b0;
      end
      out_valid_nxt = 1'b1;
      kind_nxt      = vtm_pkg::KIND_FIRED;
      slot_nxt      = vtm_pkg::ID_W'(ord_slot_r[0]);
      last_nxt      = (ord_cnt_r == vtm_pkg::CNT_W'(1));
    end

    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
      last_nxt      = 1'b1;
      if (op_r == vtm_pkg::OP_CANCEL) begin
        slot_nxt = tid_r;
        if (active_r[tid_slot]) begin
          active_nxt[tid_slot] = 1'b0;
          kind_nxt             = vtm_pkg::KIND_CANCELLED;
        end else begin
          kind_nxt = vtm_pkg::KIND_NOT_FOUND;
        end
      end else if (free_found) begin
        active_nxt[free_idx]   = 1'b1;
        deadline_nxt[free_idx] = time_r + dur_r;
        period_nxt[free_idx]   = (op_r == vtm_pkg::OP_REPEAT) ? dur_r : '0;
        kind_nxt               = vtm_pkg::KIND_STARTED;
        slot_nxt               = vtm_pkg::ID_W'(free_idx);
      end else begin
        kind_nxt = vtm_pkg::KIND_NO_FREE;
        slot_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r     <= vtm_pkg::SHIFT_RESET;
      time_r      <= '0;
      pcnt_r      <= '0;
      active_r    <= '0;
      ord_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      shift_r     <= shift_nxt;
      time_r      <= time_nxt;
      pcnt_r      <= pcnt_nxt;
      active_r    <= active_nxt;
      ord_cnt_r   <= ord_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    deadline_r <= deadline_nxt;
    period_r   <= period_nxt;
    op_r       <= op_nxt;
    dur_r      <= dur_nxt;
    tid_r      <= tid_nxt;
    ord_slot_r <= ord_slot_nxt;
    ord_late_r <= ord_late_nxt;
    kind_r     <= kind_nxt;
    slot_r     <= slot_nxt;
    last_r     <= last_nxt;
  end

endmodule

`default_nettype wire

### hw/rtl/virtual_timer_multiplexer_top.sv
// Top level of the virtual timer multiplexer.
// Joins vtm_ctrl and vtm_datapath; uses vtm_pkg, vtm_in_if and vtm_out_if.
//
// Usage: requests arrive on in_if (tick, start one-shot, start repeating,
// cancel) and results leave on out_if; a transfer happens when valid and
// ready are both high. cfg_we with cfg_wdata writes the prescale shift.
// Start and cancel requests give one result, registered from the EXEC
// state once the result register is free; the next request can transfer
// once the block is back in idle. A tick advances the prescaled time,
// then scans the eight slots one per cycle into a list ordered most
// overdue first, then sends one fired result per cycle while the result
// register is free. in_if.ready is high only while the block is idle.
// The result register holds a result while the receiver stalls; a new
// request can transfer meanwhile, and its results wait until the
// register is free.
// Reset (rst_n low at a clock edge) clears the time, the prescaler, all
// slot marks and the result valid flag, and sets the shift to four.
`default_nettype none

module virtual_timer_multiplexer_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [vtm_pkg::SHIFT_W-1:0] cfg_wdata,
  vtm_in_if.sink                           in_if,
  vtm_out_if.source                        out_if
);

  vtm_pkg::cmd_t    cmd;
  vtm_pkg::status_t status;

  vtm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_opcode (in_if.opcode),
    .in_ready  (in_if.ready),
    .status    (status),
    .cmd       (cmd)
  );

  vtm_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_opcode       (in_if.opcode),
    .in_duration     (in_if.duration),
    .in_target_id    (in_if.target_id),
    .out_valid       (out_if.valid),
    .out_ready       (out_if.ready),
    .out_result_kind (out_if.result_kind),
    .out_slot_id     (out_if.slot_id),
    .out_last        (out_if.last)
  );

endmodule

`default_nettype wire
